// ----- hdl/sha1s_pkg.sv -----
package sha1s_pkg;

  localparam int WORD_W = 32;
  localparam int ROUNDS = 80;
  localparam int RND_W  = 7;
  localparam int FILL_W = 7;
  localparam int CNT_W  = 64;
  localparam int WADDR_W = 4;

  typedef logic [4:0][WORD_W-1:0] word5_t;

  // Chaining value after reset or restart, word 0 in index 0.
  localparam word5_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                               32'hEFCDAB89, 32'h67452301};

  localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [1:0] MODE_APPEND  = 2'd0;
  localparam logic [1:0] MODE_FINISH  = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic [RND_W-1:0] RND_LAST = 7'(ROUNDS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ROUND,
    ST_FOLD,
    ST_OUT,
    ST_ERR
  } state_t;

  // What the sixteen schedule words of the block under compression are made of.
  typedef enum logic [1:0] {
    BLK_MSG,       // all sixteen words from the buffer
    BLK_PAD_ALL,   // message tail, marker, zeros and the bit length
    BLK_PAD_HEAD,  // message tail, marker and zeros; length goes to a second block
    BLK_LEN        // zeros and the bit length
  } blk_t;

  typedef struct packed {
    logic             load;
    logic             step;
    logic [RND_W-1:0] rnd;
  } core_ctl_t;

  function automatic logic [WORD_W-1:0] f_round(input logic [RND_W-1:0] rnd,
                                                input logic [WORD_W-1:0] b,
                                                input logic [WORD_W-1:0] c,
                                                input logic [WORD_W-1:0] d);
    logic [WORD_W-1:0] f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd >= 7'd40 && rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic logic [WORD_W-1:0] k_round(input logic [RND_W-1:0] rnd);
    logic [WORD_W-1:0] k;
    if (rnd < 7'd20) begin
      k = K0;
    end else if (rnd < 7'd40) begin
      k = K1;
    end else if (rnd < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

// ----- hdl/sha1s_core.sv -----
module sha1s_core
  import sha1s_pkg::*;
(
  input  logic              clk,
  input  core_ctl_t         ctl,
  input  word5_t            chain,
  input  logic [WORD_W-1:0] w_in,
  output word5_t            work
);

  word5_t                        work_r, work_nxt;
  logic [15:0][WORD_W-1:0]       sched_r, sched_nxt;
  logic [WORD_W-1:0]             w_cur;
  logic [WORD_W-1:0]             w_mix;
  logic [WORD_W-1:0]             t_sum;

  // sched_r[15] is w[i-1], sched_r[0] is w[i-16].
  assign w_mix = sched_r[13] ^ sched_r[8] ^ sched_r[2] ^ sched_r[0];
  assign w_cur = (ctl.rnd < 7'd16) ? w_in : {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};

  assign t_sum = {work_r[0][WORD_W-6:0], work_r[0][WORD_W-1:WORD_W-5]}
               + f_round(ctl.rnd, work_r[1], work_r[2], work_r[3])
               + work_r[4] + w_cur + k_round(ctl.rnd);

  always_comb begin
    work_nxt  = work_r;
    sched_nxt = sched_r;
    if (ctl.load) begin
      work_nxt = chain;
    end else if (ctl.step) begin
      work_nxt[0] = t_sum;
      work_nxt[1] = work_r[0];
      work_nxt[2] = {work_r[1][1:0], work_r[1][WORD_W-1:2]};
      work_nxt[3] = work_r[2];
      work_nxt[4] = work_r[3];
      sched_nxt   = {w_cur, sched_r[15:1]};
    end
  end

  always_ff @(posedge clk) begin
    work_r  <= work_nxt;
    sched_r <= sched_nxt;
  end

  assign work = work_r;

endmodule

// ----- hdl/sha1_stream_hash.sv -----
// Streaming SHA-1 hash over a byte stream.
// Input channel (in_valid/in_ready): each request carries in_mode and in_data_byte.
// Mode append adds one message byte, finish pads the message and returns the
// digest, restart returns the hash to its initial state. Mode 3 is ignored.
// Result channel (out_valid/out_ready): a finish returns five 32-bit digest
// words, index 0 (most significant) first, out_last on word 4. After a length
// overflow a finish returns one result with out_error and out_last set.
// The 64th byte of a block starts a compression (load, 80 rounds on one round
// unit, fold), during which in_ready is low. A finish runs one or two
// compressions and then returns the result words; a repeated finish replays
// the stored digest without a new compression. One request is in work at a
// time: in_ready is high only when idle.
// Message words sit in a 16 x 32 buffer memory with a registered read port.
// Reset (synchronous, rst_n low) restores the initial chaining value and clears
// the fill, bit count and status; there is no clearing pass over the buffer.
// When out_ready is low the current result holds and no new request is taken.
module sha1_stream_hash
  import sha1s_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_digest_word,
  output logic [2:0]        out_word_index,
  output logic              out_last,
  output logic              out_error
);

  state_t               state_r, state_nxt;
  blk_t                 blk_r, blk_nxt;
  word5_t               chain_r, chain_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     count_inc;
  logic                 finished_r, finished_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [RND_W-1:0]     rnd_r, rnd_nxt;
  logic [2:0]           idx_r, idx_nxt;
  logic [WORD_W-1:0]    word_r, word_nxt;

  logic [WORD_W-1:0]    mem [16];
  logic [WORD_W-1:0]    rdata_r;
  logic [WADDR_W-1:0]   rd_addr;
  logic                 mem_we;
  logic [WADDR_W-1:0]   wr_addr;
  logic [WORD_W-1:0]    wr_data;

  logic                 in_acc;
  logic                 out_acc;
  logic                 append_ok;
  logic [WADDR_W-1:0]   wj;
  logic [WADDR_W-1:0]   pad_idx;
  logic [WORD_W-1:0]    pad_word;
  logic [WORD_W-1:0]    w_in;
  core_ctl_t            core_ctl;
  word5_t               work;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign append_ok = !finished_r && !ovf_r;
  assign count_inc = count_r + 64'd8;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_APPEND) begin
            if (append_ok && fill_r == 7'd63) begin
              state_nxt = ST_PREP;
            end
          end else if (in_mode == MODE_FINISH) begin
            if (ovf_r) begin
              state_nxt = ST_ERR;
            end else if (finished_r) begin
              state_nxt = ST_OUT;
            end else begin
              state_nxt = ST_PREP;
            end
          end
        end
      end
      ST_PREP:  state_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == RND_LAST) state_nxt = ST_FOLD;
      ST_FOLD: begin
        case (blk_r)
          BLK_MSG:      state_nxt = ST_IDLE;
          BLK_PAD_HEAD: state_nxt = ST_PREP;
          default:      state_nxt = ST_OUT;
        endcase
      end
      ST_OUT:  if (out_acc && idx_r == 3'd4) state_nxt = ST_IDLE;
      ST_ERR:  if (out_acc) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and control strobes.
  always_comb begin
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    out_digest_word = '0;
    out_word_index  = '0;
    out_last        = 1'b0;
    out_error       = 1'b0;
    core_ctl        = '{load: 1'b0, step: 1'b0, rnd: rnd_r};
    rd_addr         = '0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_PREP: core_ctl.load = 1'b1;
      ST_ROUND: begin
        core_ctl.step = 1'b1;
        rd_addr       = rnd_r[WADDR_W-1:0] + 4'd1;
      end
      ST_OUT: begin
        out_valid       = 1'b1;
        out_digest_word = chain_r[idx_r];
        out_word_index  = idx_r;
        out_last        = (idx_r == 3'd4);
      end
      ST_ERR: begin
        out_valid = 1'b1;
        out_last  = 1'b1;
        out_error = 1'b1;
      end
      default: ;
    endcase
  end

  // Buffer write: a word is stored once its fourth byte arrives.
  assign mem_we  = in_acc && in_mode == MODE_APPEND && append_ok && fill_r[1:0] == 2'd3;
  assign wr_addr = fill_r[5:2];
  assign wr_data = {word_r[23:0], in_data_byte};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // Word fed to the round unit during the first sixteen rounds.
  assign wj      = rnd_r[WADDR_W-1:0];
  assign pad_idx = fill_r[5:2];

  always_comb begin
    case (fill_r[1:0])
      2'd0:    pad_word = {PAD_MARK, 24'h0};
      2'd1:    pad_word = {word_r[7:0], PAD_MARK, 16'h0};
      2'd2:    pad_word = {word_r[15:0], PAD_MARK, 8'h0};
      default: pad_word = {word_r[23:0], PAD_MARK};
    endcase
  end

  always_comb begin
    w_in = '0;
    case (blk_r)
      BLK_MSG: w_in = rdata_r;
      BLK_PAD_ALL: begin
        if (wj < pad_idx) begin
          w_in = rdata_r;
        end else if (wj == pad_idx) begin
          w_in = pad_word;
        end else if (wj == 4'd14) begin
          w_in = count_r[63:32];
        end else if (wj == 4'd15) begin
          w_in = count_r[31:0];
        end
      end
      BLK_PAD_HEAD: begin
        if (wj < pad_idx) begin
          w_in = rdata_r;
        end else if (wj == pad_idx) begin
          w_in = pad_word;
        end
      end
      BLK_LEN: begin
        if (wj == 4'd14) begin
          w_in = count_r[63:32];
        end else if (wj == 4'd15) begin
          w_in = count_r[31:0];
        end
      end
      default: w_in = '0;
    endcase
  end

  sha1s_core u_core (
    .clk   (clk),
    .ctl   (core_ctl),
    .chain (chain_r),
    .w_in  (w_in),
    .work  (work)
  );

  // Datapath and status registers.
  always_comb begin
    blk_nxt      = blk_r;
    chain_nxt    = chain_r;
    fill_nxt     = fill_r;
    count_nxt    = count_r;
    finished_nxt = finished_r;
    ovf_nxt      = ovf_r;
    rnd_nxt      = rnd_r;
    idx_nxt      = idx_r;
    word_nxt     = word_r;
    case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        rnd_nxt = '0;
        if (in_acc) begin
          if (in_mode == MODE_APPEND) begin
            if (append_ok) begin
              word_nxt  = wr_data;
              fill_nxt  = fill_r + 7'd1;
              count_nxt = count_inc;
              if (count_inc == '0) begin
                ovf_nxt = 1'b1;
              end
              blk_nxt = BLK_MSG;
            end
          end else if (in_mode == MODE_FINISH) begin
            blk_nxt = (fill_r >= 7'd56) ? BLK_PAD_HEAD : BLK_PAD_ALL;
          end else if (in_mode == MODE_RESTART) begin
            chain_nxt    = H_INIT;
            fill_nxt     = '0;
            count_nxt    = '0;
            finished_nxt = 1'b0;
            ovf_nxt      = 1'b0;
          end
        end
      end
      ST_PREP:  rnd_nxt = '0;
      ST_ROUND: rnd_nxt = rnd_r + 7'd1;
      ST_FOLD: begin
        for (int i = 0; i < 5; i++) begin
          chain_nxt[i] = chain_r[i] + work[i];
        end
        case (blk_r)
          BLK_MSG: fill_nxt = '0;
          BLK_PAD_HEAD: blk_nxt = BLK_LEN;
          default: begin
            fill_nxt     = '0;
            count_nxt    = '0;
            finished_nxt = 1'b1;
          end
        endcase
      end
      ST_OUT: if (out_acc) idx_nxt = idx_r + 3'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      blk_r      <= BLK_MSG;
      chain_r    <= H_INIT;
      fill_r     <= '0;
      count_r    <= '0;
      finished_r <= 1'b0;
      ovf_r      <= 1'b0;
      rnd_r      <= '0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      blk_r      <= blk_nxt;
      chain_r    <= chain_nxt;
      fill_r     <= fill_nxt;
      count_r    <= count_nxt;
      finished_r <= finished_nxt;
      ovf_r      <= ovf_nxt;
      rnd_r      <= rnd_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

`ifndef SYNTHESIS
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last)
    else $error("error result without last");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while a result is pending");

  a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND && rnd_r == RND_LAST |=> state_r == ST_FOLD)
    else $error("compression did not end after the last round");

  a_block_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FOLD && blk_r == BLK_MSG |=> fill_r == '0)
    else $error("fill not cleared after a full block");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word_index != 3'd5 && out_word_index != 3'd6 &&
                  out_word_index != 3'd7)
    else $error("digest word index out of range");
`endif

endmodule

// ----- tb/sha1_stream_hash_tb.sv -----
`timescale 1ns / 1ps

module sha1_stream_hash_tb;
  import sha1s_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int MSG_ITEMS = 460;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [WORD_W-1:0] digest_word;
    logic [2:0]        word_index;
    logic              last;
    logic              error;
  } hash_word_t;

  typedef struct packed {
    logic [1:0]   mode;
    logic [7:0]   data;
    logic         known;
    logic [159:0] digest;
  } hash_req_t;

  // Directed requests. Digests are typed in only for the empty message and "abc".
  localparam int DIR_ROWS = 23;
  localparam hash_req_t DIR_TBL [DIR_ROWS] = '{
    '{MODE_FINISH,  8'h00, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709},
    '{MODE_FINISH,  8'h00, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709},
    '{MODE_APPEND,  8'h00, 1'b0, 160'h0},
    '{MODE_FINISH,  8'h00, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709},
    '{MODE_RESTART, 8'h00, 1'b0, 160'h0},
    '{MODE_UNUSED,  8'hFF, 1'b0, 160'h0},
    '{MODE_APPEND,  8'h61, 1'b0, 160'h0},
    '{MODE_APPEND,  8'h62, 1'b0, 160'h0},
    '{MODE_APPEND,  8'h63, 1'b0, 160'h0},
    '{MODE_FINISH,  8'h00, 1'b1, 160'ha9993e364706816aba3e25717850c26c9cd0d89d},
    '{MODE_RESTART, 8'hFF, 1'b0, 160'h0},
    '{MODE_APPEND,  8'hFF, 1'b0, 160'h0},
    '{MODE_APPEND,  8'h00, 1'b0, 160'h0},
    '{MODE_UNUSED,  8'h00, 1'b0, 160'h0},
    '{MODE_APPEND,  8'h80, 1'b0, 160'h0},
    '{MODE_APPEND,  8'h7F, 1'b0, 160'h0},
    '{MODE_FINISH,  8'hFF, 1'b0, 160'h0},
    '{MODE_APPEND,  8'hFF, 1'b0, 160'h0},
    '{MODE_FINISH,  8'h00, 1'b0, 160'h0},
    '{MODE_RESTART, 8'h00, 1'b0, 160'h0},
    '{MODE_RESTART, 8'h00, 1'b0, 160'h0},
    '{MODE_FINISH,  8'h00, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709},
    '{MODE_RESTART, 8'h00, 1'b0, 160'h0}
  };

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_mode = MODE_RESTART;
  logic [7:0]        in_data_byte = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [WORD_W-1:0] out_digest_word;
  logic [2:0]        out_word_index;
  logic              out_last;
  logic              out_error;

  sha1_stream_hash u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last        (out_last),
    .out_error       (out_error)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hash state as the block should hold it.
  logic [WORD_W-1:0] hash_chain [5];
  logic [7:0]        blk_bytes [64];
  int                blk_fill;
  logic [63:0]       msg_bits;
  logic              digest_done;
  logic              len_overflow;

  hash_word_t digest_words_q [$];

  int fail_cnt;
  int words_seen;
  int req_cnt;
  int finish_cnt;
  int blk_cnt;
  int burst_left;

  function automatic logic [WORD_W-1:0] rol32(input logic [WORD_W-1:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void hash_restart();
    for (int i = 0; i < 5; i++) hash_chain[i] = H_INIT[i];
    blk_fill = 0;
    msg_bits = '0;
    digest_done = 1'b0;
    len_overflow = 1'b0;
  endfunction

  function automatic void compress_blk();
    logic [WORD_W-1:0] w [80];
    logic [WORD_W-1:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    end
    for (int i = 16; i < 80; i++) begin
      w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    end
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    e = hash_chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = rol32(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    hash_chain[0] += a;
    hash_chain[1] += b;
    hash_chain[2] += c;
    hash_chain[3] += d;
    hash_chain[4] += e;
    blk_fill = 0;
    blk_cnt++;
  endfunction

  // Marker, zero fill and the 64-bit length; a second block when the tail is too long.
  function automatic void pad_and_close();
    blk_bytes[blk_fill & 63] = PAD_MARK;
    blk_fill++;
    if (blk_fill > 56) begin
      while (blk_fill < 64) begin
        blk_bytes[blk_fill] = 8'h00;
        blk_fill++;
      end
      compress_blk();
    end
    while (blk_fill < 56) begin
      blk_bytes[blk_fill] = 8'h00;
      blk_fill++;
    end
    for (int i = 0; i < 8; i++) blk_bytes[56+i] = msg_bits[63-8*i -: 8];
    compress_blk();
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    msg_bits = '0;
    digest_done = 1'b1;
  endfunction

  function automatic void queue_digest(input logic [159:0] dg);
    hash_word_t hw;
    for (int i = 0; i < 5; i++) begin
      hw.digest_word = dg[159-32*i -: 32];
      hw.word_index  = 3'(i);
      hw.last        = (i == 4);
      hw.error       = 1'b0;
      digest_words_q.push_back(hw);
    end
  endfunction

  function automatic void predict_request(input logic [1:0] mode, input logic [7:0] data,
                                          input logic known, input logic [159:0] fixed_dg);
    hash_word_t hw;
    case (mode)
      MODE_APPEND: begin
        if (!digest_done && !len_overflow) begin
          blk_bytes[blk_fill & 63] = data;
          blk_fill++;
          msg_bits += 64'd8;
          if (msg_bits == '0) len_overflow = 1'b1;
          if (blk_fill >= 64) compress_blk();
        end
      end
      MODE_FINISH: begin
        finish_cnt++;
        if (len_overflow) begin
          hw = '{digest_word: '0, word_index: 3'd0, last: 1'b1, error: 1'b1};
          digest_words_q.push_back(hw);
        end else begin
          if (!digest_done) pad_and_close();
          if (known) begin
            queue_digest(fixed_dg);
          end else begin
            queue_digest({hash_chain[0], hash_chain[1], hash_chain[2],
                          hash_chain[3], hash_chain[4]});
          end
        end
      end
      MODE_RESTART: hash_restart();
      default: ;
    endcase
  endfunction

  // Bursts of back-to-back requests with random idle gaps in between.
  task automatic send_req(input logic [1:0] mode, input logic [7:0] data,
                          input logic known = 1'b0, input logic [159:0] fixed_dg = '0);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_data_byte <= data;
    do @(posedge clk); while (!in_ready);
    predict_request(mode, data, known, fixed_dg);
    req_cnt++;
    burst_left--;
  endtask

  // Result side: stretches of full readiness, random stalls and a fixed stall pattern.
  int rdy_style;
  int rdy_left;
  int rdy_tick;

  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_style = $urandom_range(0, 2);
      rdy_left  = $urandom_range(20, 150);
    end
    rdy_left--;
    rdy_tick++;
    case (rdy_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 2) != 0);
      default: out_ready <= ((rdy_tick % 7) >= 3);
    endcase
  end

  function automatic void note_fail(input string what, input hash_word_t exp_w,
                                    input hash_word_t got_w);
    if (fail_cnt < MAX_SHOWN) begin
      $display("%0t %s: expected word %h idx %0d last %b err %b,",
               $time, what, exp_w.digest_word, exp_w.word_index, exp_w.last, exp_w.error);
      $display("    got word %h idx %0d last %b err %b",
               got_w.digest_word, got_w.word_index, got_w.last, got_w.error);
    end
    fail_cnt++;
  endfunction

  always @(posedge clk) begin
    hash_word_t got_w;
    hash_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      got_w = '{digest_word: out_digest_word, word_index: out_word_index,
                last: out_last, error: out_error};
      words_seen++;
      if (digest_words_q.size() == 0) begin
        note_fail("unexpected result", '0, got_w);
      end else begin
        exp_w = digest_words_q.pop_front();
        if (got_w !== exp_w) note_fail("digest mismatch", exp_w, got_w);
      end
    end
  end

  initial begin
    int len;
    int pick;
    int boundary [10];
    boundary = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120};
    hash_restart();
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    fail_cnt = 0;
    words_seen = 0;
    req_cnt = 0;
    finish_cnt = 0;
    blk_cnt = 0;
    burst_left = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_req(DIR_TBL[r].mode, DIR_TBL[r].data, DIR_TBL[r].known, DIR_TBL[r].digest);
    end

    // Random messages, mostly well formed, lengths biased to the padding boundaries.
    while (req_cnt < MSG_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) len = boundary[$urandom_range(0, 9)];
      else if (pick < 7) len = $urandom_range(0, 20);
      else len = $urandom_range(0, 130);
      if ($urandom_range(0, 7) != 0) begin
        send_req(MODE_RESTART, 8'($urandom_range(0, 255)));
      end
      for (int j = 0; j < len && req_cnt < MSG_ITEMS; j++) begin
        if ($urandom_range(0, 29) == 0) send_req(MODE_UNUSED, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 59) == 0) begin
          send_req(MODE_RESTART, 8'($urandom_range(0, 255)));
        end
        send_req(MODE_APPEND, 8'($urandom_range(0, 255)));
      end
      send_req(MODE_FINISH, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) begin
        send_req(MODE_FINISH, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 4) == 0) send_req(MODE_APPEND, 8'($urandom_range(0, 255)));
    end
    in_valid <= 1'b0;

    while (digest_words_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d requests including %0d finishes; %0d blocks compressed.",
             req_cnt, finish_cnt, blk_cnt);
    $display("Checked %0d digest words, %0d mismatches.", words_seen, fail_cnt);
    if (fail_cnt == 0 && digest_words_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d digest words outstanding.", digest_words_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
